/* hw/rtl/lrd_pkg.sv */
// Shared types, codes and the CRC-32C byte update for the log record deframer.
package lrd_pkg;

  localparam int unsigned HdrBytes = 16;
  localparam logic [31:0] Crc32cPoly = 32'h82F63B78;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_STOPPED = 3'b100
  } lrd_phase_e;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_DONE    = 2'd2
  } lrd_kind_e;

  // Input action codes
  localparam logic ActByte = 1'b0;
  localparam logic ActEof  = 1'b1;

  // Reflected CRC-32C, one byte, bitwise
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ Crc32cPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/lrd_stream_if.sv */
// Valid/ready channel interfaces for the deframer input and result streams.
interface lrd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] file_byte;

  modport source (output valid, action, file_byte, input ready);
  modport sink   (input valid, action, file_byte, output ready);
endinterface

interface lrd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic        record_end;
  logic        record_good;
  logic [63:0] record_seq;
  logic [31:0] record_crc;
  logic        recovery_ok;
  logic [63:0] resume_seq;

  modport source (output valid, kind, payload_byte, record_end, record_good, record_seq,
                  record_crc, recovery_ok, resume_seq, input ready);
  modport sink   (input valid, kind, payload_byte, record_end, record_good, record_seq,
                  record_crc, recovery_ok, resume_seq, output ready);
endinterface

/* hw/rtl/log_record_deframer_crc32c_unit.sv */
// Log record deframer: parses 16-byte record headers and checks payload CRC-32C.
//
// Usage:
//   in_i  : one transfer per file byte (action 0) or end of file (action 1).
//   out_o : one transfer per payload byte (kind 0), per empty record (kind 1)
//           and per end of file (kind 2). Header bytes and bytes seen after a
//           CRC failure give no result.
//   cfg   : cfg_we_i/cfg_wdata_i load the resume sequence number reported
//           while no good record has been seen. Write only while idle.
// Latency: a result appears on out_o in the cycle after its input transfer.
// Throughput: one input transfer per cycle while no held result stalls it,
//   limited by the byte-wide CRC update and 32-bit length compare done
//   between the input handshake and the result register.
// Stalls: the result register holds while out_o.ready is low; in_i.ready
//   drops only while a result is held and out_o.ready is low, so a new input
//   is taken in the same cycle a held result leaves.
// Reset: parser returns to the header phase, counters and header fields
//   clear, CRC register is all ones, resume value is zero.
// End of file restarts the parser but keeps the resume value.
module log_record_deframer_crc32c_unit
  import lrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  lrd_in_if.sink      in_i,
  lrd_out_if.source   out_o
);

  // Parser state
  lrd_phase_e  phase_q, phase_d;
  logic [3:0]  hdr_pos_q, hdr_pos_d;     // header byte index
  logic [31:0] pay_cnt_q, pay_cnt_d;     // payload bytes taken
  logic [63:0] hdr_seq_q, hdr_seq_d;
  logic [31:0] hdr_len_q, hdr_len_d;
  logic [31:0] hdr_crc_q, hdr_crc_d;
  logic [31:0] run_crc_q, run_crc_d;
  logic [63:0] resume_q, resume_d;
  logic        failed_q, failed_d;

  // Result register
  logic        res_valid_q;
  logic        emit;
  lrd_kind_e   kind_q, kind_d;
  logic [7:0]  pbyte_q, pbyte_d;
  logic        rend_q, rend_d;
  logic        rgood_q, rgood_d;
  logic [63:0] rseq_q, rseq_d;
  logic [31:0] rcrc_q, rcrc_d;
  logic        rok_q, rok_d;
  logic [63:0] rres_q, rres_d;

  logic        accept;
  logic [63:0] seq_n;
  logic [31:0] len_n, crc_n, byte_crc;
  logic        good;

  assign in_i.ready = !res_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    phase_d   = phase_q;
    hdr_pos_d = hdr_pos_q;
    pay_cnt_d = pay_cnt_q;
    hdr_seq_d = hdr_seq_q;
    hdr_len_d = hdr_len_q;
    hdr_crc_d = hdr_crc_q;
    run_crc_d = run_crc_q;
    resume_d  = resume_q;
    failed_d  = failed_q;
    emit      = 1'b0;
    kind_d    = KIND_PAYLOAD;
    pbyte_d   = 8'h00;
    rend_d    = 1'b0;
    rgood_d   = 1'b0;
    rseq_d    = 64'h0;
    rcrc_d    = 32'h0;
    rok_d     = 1'b0;
    rres_d    = 64'h0;
    good      = 1'b0;

    // Header field merge for the current byte
    seq_n = hdr_seq_q;
    len_n = hdr_len_q;
    crc_n = hdr_crc_q;
    if (!hdr_pos_q[3]) begin
      seq_n = hdr_seq_q | (64'(in_i.file_byte) << {hdr_pos_q[2:0], 3'b000});
    end else if (!hdr_pos_q[2]) begin
      len_n = hdr_len_q | (32'(in_i.file_byte) << {hdr_pos_q[1:0], 3'b000});
    end else begin
      crc_n = hdr_crc_q | (32'(in_i.file_byte) << {hdr_pos_q[1:0], 3'b000});
    end

    byte_crc = crc32c_byte(run_crc_q, in_i.file_byte);

    if (cfg_we_i) begin
      resume_d = cfg_wdata_i;
    end

    if (accept) begin
      if (in_i.action == ActEof) begin
        emit      = 1'b1;
        kind_d    = KIND_DONE;
        rok_d     = !failed_q && (phase_q == PH_HEADER) && (hdr_pos_q == 4'd0);
        rres_d    = resume_q;
        phase_d   = PH_HEADER;
        hdr_pos_d = 4'd0;
        pay_cnt_d = 32'd0;
        hdr_seq_d = 64'h0;
        hdr_len_d = 32'h0;
        hdr_crc_d = 32'h0;
        run_crc_d = CrcInit;
        failed_d  = 1'b0;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            hdr_seq_d = seq_n;
            hdr_len_d = len_n;
            hdr_crc_d = crc_n;
            hdr_pos_d = hdr_pos_q + 4'd1;
            if (hdr_pos_q == 4'(HdrBytes - 1)) begin
              pay_cnt_d = 32'd0;
              run_crc_d = CrcInit;
              if (len_n == 32'd0) begin
                // empty record: good when stored CRC is that of no bytes
                good    = (crc_n == 32'h0);
                emit    = 1'b1;
                kind_d  = KIND_EMPTY;
                rend_d  = 1'b1;
                rgood_d = good;
                rseq_d  = seq_n;
                rcrc_d  = crc_n;
                if (good) begin
                  resume_d  = seq_n + 64'd1;
                  hdr_seq_d = 64'h0;
                  hdr_crc_d = 32'h0;
                end else begin
                  failed_d = 1'b1;
                  phase_d  = PH_STOPPED;
                end
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            run_crc_d = byte_crc;
            pay_cnt_d = pay_cnt_q + 32'd1;
            emit      = 1'b1;
            kind_d    = KIND_PAYLOAD;
            pbyte_d   = in_i.file_byte;
            rseq_d    = hdr_seq_q;
            rcrc_d    = hdr_crc_q;
            if (pay_cnt_d == hdr_len_q) begin
              good    = (~byte_crc == hdr_crc_q);
              rend_d  = 1'b1;
              rgood_d = good;
              if (good) begin
                resume_d  = hdr_seq_q + 64'd1;
                phase_d   = PH_HEADER;
                pay_cnt_d = 32'd0;
                hdr_seq_d = 64'h0;
                hdr_len_d = 32'h0;
                hdr_crc_d = 32'h0;
                run_crc_d = CrcInit;
              end else begin
                failed_d = 1'b1;
                phase_d  = PH_STOPPED;
              end
            end
          end
          default: begin
            // stopped: bytes are dropped until end of file
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_pos_q   <= 4'd0;
      pay_cnt_q   <= 32'd0;
      hdr_seq_q   <= 64'h0;
      hdr_len_q   <= 32'h0;
      hdr_crc_q   <= 32'h0;
      run_crc_q   <= CrcInit;
      resume_q    <= 64'h0;
      failed_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      hdr_pos_q <= hdr_pos_d;
      pay_cnt_q <= pay_cnt_d;
      hdr_seq_q <= hdr_seq_d;
      hdr_len_q <= hdr_len_d;
      hdr_crc_q <= hdr_crc_d;
      run_crc_q <= run_crc_d;
      resume_q  <= resume_d;
      failed_q  <= failed_d;
      if (in_i.ready) begin
        res_valid_q <= accept && emit;
      end
    end
  end

  // Result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q  <= kind_d;
      pbyte_q <= pbyte_d;
      rend_q  <= rend_d;
      rgood_q <= rgood_d;
      rseq_q  <= rseq_d;
      rcrc_q  <= rcrc_d;
      rok_q   <= rok_d;
      rres_q  <= rres_d;
    end
  end

  assign out_o.valid        = res_valid_q;
  assign out_o.kind         = kind_q;
  assign out_o.payload_byte = pbyte_q;
  assign out_o.record_end   = rend_q;
  assign out_o.record_good  = rgood_q;
  assign out_o.record_seq   = rseq_q;
  assign out_o.record_crc   = rcrc_q;
  assign out_o.recovery_ok  = rok_q;
  assign out_o.resume_seq   = rres_q;

endmodule

/* hw/rtl/lrd_checker.sv */
// Port-level checks for the log record deframer, bound to the top level.
module lrd_checker
  import lrd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_action_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic        out_record_end_i,
  input logic        out_record_good_i,
  input logic [63:0] out_resume_seq_i
);

  // Held result stays valid and keeps its kind and resume value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i)
      && $stable(out_resume_seq_i))
    else $error("result changed while stalled");

  // Input is never blocked while no result is pending
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // End of file always yields a recovery result next cycle
  a_eof_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == ActEof)
      |=> out_valid_i && (out_kind_i == KIND_DONE))
    else $error("end of file gave no recovery result");

  // A good verdict only on a record-closing result
  a_good_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_record_good_i |-> out_record_end_i && (out_kind_i != KIND_DONE))
    else $error("good verdict without record end");

endmodule

bind log_record_deframer_crc32c_unit lrd_checker u_lrd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_action_i       (in_i.action),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_kind_i        (out_o.kind),
  .out_record_end_i  (out_o.record_end),
  .out_record_good_i (out_o.record_good),
  .out_resume_seq_i  (out_o.resume_seq)
);

/* sim/log_record_deframer_crc32c_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the log record deframer with CRC-32C check.
module log_record_deframer_crc32c_unit_test;
  import lrd_pkg::*;

  localparam int unsigned RandomItems = 1350;
  localparam int unsigned IdlePct = 7;
  localparam int unsigned ClkPeriod = 12;
  // Time limit, well above the slowest correct run.
  localparam int unsigned LimitCycles = 200000;

  // One deframer result as it appears on out_o
  typedef struct {
    lrd_kind_e   kind;
    logic [7:0]  payload_byte;
    logic        record_end;
    logic        record_good;
    logic [63:0] record_seq;
    logic [31:0] record_crc;
    logic        recovery_ok;
    logic [63:0] resume_seq;
  } deframer_out_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [63:0] cfg_wdata;

  lrd_in_if  in_ch ();
  lrd_out_if out_ch ();

  log_record_deframer_crc32c_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Parser mirror: phase, header capture, running CRC, resume number.
  // hdr_bits holds the 16 header bytes as {crc, length, seq}, little-endian.
  // ---------------------------------------------------------------------------
  lrd_phase_e    parse_ph;
  logic [31:0]   byte_count;
  logic [127:0]  hdr_bits;
  logic [31:0]   crc_acc;
  logic [63:0]   resume_lsn;
  logic          fail_seen;

  deframer_out_t deframed_due[$];   // results owed by the block, oldest first
  deframer_out_t got_want;
  logic [7:0]    record_body[$];    // payload of the record being built

  int unsigned   mismatches = 0;
  int unsigned   live_items = 0;    // transfers the block did not just drop
  bit            steady = 1'b0;     // no idling on either side while set
  int unsigned   hold_request = 0;  // receiver hold-off, picked up by its process
  int unsigned   hold_left = 0;

  // Castagnoli CRC, reflected, one data bit per step
  function automatic logic [31:0] crc32c_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c;
    for (int k = 0; k < 8; k++) begin
      v = (v >> 1) ^ ((v[0] ^ b[k]) ? Crc32cPoly : 32'h0);
    end
    return v;
  endfunction

  function automatic logic [31:0] body_crc();
    logic [31:0] c;
    c = CrcInit;
    foreach (record_body[i]) c = crc32c_update(c, record_body[i]);
    return ~c;
  endfunction

  // Start over as after reset; the resume number survives.
  function automatic void clear_parser();
    parse_ph   = PH_HEADER;
    byte_count = '0;
    hdr_bits   = '0;
    crc_acc    = CrcInit;
    fail_seen  = 1'b0;
  endfunction

  // Close a record: good moves the resume point, bad stops the parser.
  function automatic void close_record(input logic good);
    if (good) begin
      resume_lsn = hdr_bits[63:0] + 64'd1;
      parse_ph   = PH_HEADER;
      byte_count = '0;
      hdr_bits   = '0;
      crc_acc    = CrcInit;
    end else begin
      fail_seen = 1'b1;
      parse_ph  = PH_STOPPED;
    end
  endfunction

  // Advance the mirror by one accepted input transfer, queue what it owes.
  function automatic void deframe_step(input logic act, input logic [7:0] b);
    deframer_out_t r;
    r.kind         = KIND_PAYLOAD;
    r.payload_byte = '0;
    r.record_end   = 1'b0;
    r.record_good  = 1'b0;
    r.record_seq   = '0;
    r.record_crc   = '0;
    r.recovery_ok  = 1'b0;
    r.resume_seq   = '0;
    if (act == ActEof || parse_ph != PH_STOPPED) live_items++;

    if (act == ActEof) begin
      // Clean only at a record boundary with nothing failed
      r.kind        = KIND_DONE;
      r.recovery_ok = !fail_seen && parse_ph == PH_HEADER && byte_count == 0;
      r.resume_seq  = resume_lsn;
      deframed_due.push_back(r);
      clear_parser();
      return;
    end

    case (parse_ph)
      PH_HEADER: begin
        hdr_bits[8*byte_count[3:0] +: 8] = hdr_bits[8*byte_count[3:0] +: 8] | b;
        byte_count = byte_count + 1;
        if (byte_count < HdrBytes) return;
        byte_count = '0;
        crc_acc    = CrcInit;
        if (hdr_bits[95:64] == 0) begin
          // Empty record: good only if the stored checksum is that of no bytes
          r.kind        = KIND_EMPTY;
          r.record_end  = 1'b1;
          r.record_good = (hdr_bits[127:96] == 0);
          r.record_seq  = hdr_bits[63:0];
          r.record_crc  = hdr_bits[127:96];
          deframed_due.push_back(r);
          close_record(r.record_good);
        end else begin
          parse_ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_acc    = crc32c_update(crc_acc, b);
        byte_count = byte_count + 1;
        r.payload_byte = b;
        r.record_seq   = hdr_bits[63:0];
        r.record_crc   = hdr_bits[127:96];
        if (byte_count >= hdr_bits[95:64]) begin
          r.record_end  = 1'b1;
          r.record_good = (~crc_acc == hdr_bits[127:96]);
        end
        deframed_due.push_back(r);
        if (r.record_end) close_record(r.record_good);
      end
      default: ;  // stopped: byte dropped
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #(LimitCycles * ClkPeriod);
    $display("log_record_deframer_crc32c_unit_test: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, long hold-offs on request, none in steady.
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t ns: %s expected %0h got %0h", $time, field, want, got);
    end
  endtask

  // Each result transfer is checked against the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (deframed_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t ns: result transfer with none owed, kind %0d", $time, out_ch.kind);
      end else begin
        got_want = deframed_due.pop_front();
        report_field("kind", got_want.kind, out_ch.kind);
        report_field("payload_byte", got_want.payload_byte, out_ch.payload_byte);
        report_field("record_end", got_want.record_end, out_ch.record_end);
        report_field("record_good", got_want.record_good, out_ch.record_good);
        report_field("record_seq", got_want.record_seq, out_ch.record_seq);
        report_field("record_crc", got_want.record_crc, out_ch.record_crc);
        report_field("recovery_ok", got_want.recovery_ok, out_ch.recovery_ok);
        report_field("resume_seq", got_want.resume_seq, out_ch.resume_seq);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. All tasks are entered right after a rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic act, input logic [7:0] b);
    if (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.file_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    deframe_step(act, b);
  endtask

  task automatic send_eof();
    send_item(ActEof, 8'($urandom));
  endtask

  task automatic send_header(input logic [63:0] seq, input logic [31:0] len,
                             input logic [31:0] crc);
    logic [127:0] hdr;
    hdr = {crc, len, seq};
    for (int i = 0; i < HdrBytes; i++) send_item(ActByte, hdr[8*i +: 8]);
  endtask

  task automatic send_body();
    foreach (record_body[i]) send_item(ActByte, record_body[i]);
  endtask

  task automatic fill_body(input int unsigned n);
    record_body.delete();
    repeat (n) record_body.push_back(8'($urandom));
  endtask

  // Wait until every owed result has left, plus a short settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (deframed_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Register write, only while the block is idle
  task automatic write_resume_lsn(input logic [63:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    resume_lsn = value;
  endtask

  function automatic logic [63:0] pick_seq();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'h8000_0000_0000_0000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly short payloads, some empty, a few longer
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 15) return $urandom_range(13, 64);
    return $urandom_range(1, 12);
  endfunction

  // Well-formed record; corrupt flips one bit of the checksum or the payload.
  task automatic random_record(input bit corrupt);
    int unsigned n;
    int unsigned hit;
    logic [31:0] crc_field;
    n = pick_len();
    fill_body(n);
    crc_field = body_crc();
    if (corrupt) begin
      if (n == 0 || $urandom_range(0, 1) == 0) begin
        crc_field ^= 32'h1 << $urandom_range(0, 31);
      end else begin
        hit = $urandom_range(0, n - 1);
        record_body[hit] ^= 8'h1 << $urandom_range(0, 7);
      end
    end
    send_header(pick_seq(), n, crc_field);
    send_body();
  endtask

  // One log file: a run of records, maybe a torn tail, then end of file.
  task automatic random_file();
    int unsigned n_rec;
    int unsigned sel;
    int unsigned n;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      // garbage from the first byte: random header, often a huge length
      repeat ($urandom_range(1, 40)) send_item(ActByte, 8'($urandom));
      send_eof();
      return;
    end
    n_rec = $urandom_range(1, 6);
    repeat (n_rec) random_record($urandom_range(0, 99) < 8);
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      // torn header
      repeat ($urandom_range(1, 15)) send_item(ActByte, 8'($urandom));
    end else if (sel < 20) begin
      // torn payload: header promises more than arrives
      n = $urandom_range(0, 8);
      fill_body(n);
      send_header(pick_seq(), n + $urandom_range(1, 8), $urandom);
      send_body();
    end
    send_eof();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // End of file on an empty log, twice: clean, resume stays at reset value.
  task automatic test_eof_after_reset();
    send_item(ActEof, 8'h00);
    send_item(ActEof, 8'hFF);
  endtask

  // Register extremes and resume wrap on the largest sequence number.
  task automatic test_resume_register();
    write_resume_lsn('1);
    send_eof();
    record_body.delete();
    send_header('1, 32'd0, 32'd0);   // good empty record, resume wraps to zero
    send_eof();
    write_resume_lsn(64'h8000_0000_0000_0000);
    send_eof();
    write_resume_lsn('0);
  endtask

  task automatic test_special_records();
    // empty record with a nonzero checksum: bad verdict, bytes after it dropped
    record_body.delete();
    send_header(64'h0123_4567_89AB_CDEF, 32'd0, 32'h0000_0001);
    repeat (3) send_item(ActByte, 8'hA5);
    send_eof();
    // good payload at the byte extremes, then a record with a wrong checksum
    record_body.push_back(8'h00);
    record_body.push_back(8'hFF);
    send_header('0, 32'd2, body_crc());
    send_body();
    send_header('1, 32'd2, ~body_crc());
    send_body();
    send_eof();
    // torn payload under an all-ones length and checksum
    send_header(64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ActByte, 8'h5A);
    send_item(ActByte, 8'hC3);
    send_eof();
    // torn header
    repeat (7) send_item(ActByte, 8'($urandom));
    send_eof();
  endtask

  // Receiver holds off while a long record streams in; input must stall.
  task automatic test_backpressure();
    hold_request = 300;
    fill_body(48);
    send_header(pick_seq(), 32'd48, body_crc());
    send_body();
    send_eof();
    wait_drained();
  endtask

  // Random files until the whole run has taken about RandomItems live items
  task automatic test_random_files();
    int unsigned target;
    int unsigned file_idx;
    target   = RandomItems;
    file_idx = 0;
    while (live_items < target) begin
      // a stretch of files with no idling on either side
      steady = (file_idx >= 3 && file_idx < 10);
      if ($urandom_range(0, 99) < 15) begin
        case ($urandom_range(0, 3))
          0:       write_resume_lsn('0);
          1:       write_resume_lsn('1);
          default: write_resume_lsn({$urandom, $urandom});
        endcase
      end
      random_file();
      file_idx++;
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    resume_lsn = '0;
    clear_parser();
    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ActByte;
    in_ch.file_byte <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_eof_after_reset();
    test_resume_register();
    test_special_records();
    test_backpressure();
    test_random_files();

    wait_drained();
    if (mismatches == 0 && deframed_due.size() == 0)
      $display("log_record_deframer_crc32c_unit_test: clean");
    else
      $display("log_record_deframer_crc32c_unit_test: errors");
    $finish;
  end

endmodule
